// File: sv/hsv_to_rgb_percent_unit_assert.svh
// ---------------------------------------------------------------------------
// hsv_to_rgb_percent_unit_assert.svh
// Assertion macros for the HSV to RGB converter. With SYNTH defined the
// macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PERCENT_UNIT_ASSERT_SVH
`define HSV_TO_RGB_PERCENT_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every enabled clock edge.
`define HSVRGB_CHECK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Same-cycle implication.
`define HSVRGB_CHECK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// Next-cycle implication.
`define HSVRGB_CHECK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define HSVRGB_CHECK(label, clk, rst_n, prop)
`define HSVRGB_CHECK_IMPL(label, clk, rst_n, ante, cons)
`define HSVRGB_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// Widths, constants and types shared by the HSV to RGB converter files.
// ---------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HueW   = 9;
  localparam int PctW   = 7;
  localparam int ChanW  = 8;
  localparam int PackW  = 3 * ChanW;
  localparam int RemW   = 6;
  localparam int ProdW  = 14;   // product of two percentages, up to 10000
  localparam int LevelW = 20;   // channel level scaled by 6000, up to 600000
  localparam int RecipW = 21;
  localparam int QuotW  = 9;    // unsaturated byte value, up to 256
  localparam int QuotLo = 32;   // fraction bits of the reciprocal

  localparam logic [HueW-1:0]   HueWrap    = 9'd360;
  localparam logic [HueW-1:0]   SectorSpan = 9'd60;
  localparam logic [PctW-1:0]   PctMax     = 7'd100;
  localparam logic [LevelW-1:0] LevelScale = 20'd6000;
  localparam logic [LevelW-1:0] MinScale   = 20'd60;
  // 4 * ceil(2^32 / 9375): level * 256 / 600000 == level * 4 / 9375, exact
  // over the whole level range.
  localparam logic [RecipW-1:0] ByteRecip  = 21'd1832520;
  localparam logic [ChanW-1:0]  ChanMax    = 8'd255;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [ChanW-1:0]  chan_t;

  // Color wheel sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SecRedYellow    = 3'd0,
    SecYellowGreen  = 3'd1,
    SecGreenCyan    = 3'd2,
    SecCyanBlue     = 3'd3,
    SecBlueMagenta  = 3'd4,
    SecMagentaRed   = 3'd5
  } sector_t;

endpackage

// File: sv/hsvrgb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsvrgb_in_if / hsvrgb_out_if
// Valid/ready channels carrying one HSV word in and one RGB word out.
// ---------------------------------------------------------------------------
interface hsvrgb_in_if
  import hsvrgb_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue;
  logic [PctW-1:0] saturation;
  logic [PctW-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_out_if
  import hsvrgb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [PackW-1:0] packed_color;

  modport source (output valid, output red, output green, output blue,
                  output packed_color, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input packed_color, output ready);
endinterface

// File: sv/hsv_to_rgb_percent_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_to_rgb_percent_unit
// Five-stage pipelined HSV (degrees, percent) to 8-bit RGB converter.
// ---------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled. A word
// accepted at the input passes four internal register stages (s1 to s4) and
// is then presented from the output register. A new word can enter in every
// cycle while the output is not stalled, so the sustained rate is one word
// per cycle, set by the five register stages that all advance together.
// When the output is stalled the whole pipeline holds and in_hsv ready drops,
// so nothing is lost or repeated. Hue wraps modulo 360 and saturation and
// brightness above 100 are clamped to 100. Channel levels are computed
// exactly, scaled by 6000, then each becomes floor(level*256/600000)
// saturated at 255, so full brightness gives 255 rather than wrapping. The
// packed word holds blue in bits 23:16, green in 15:8 and red in 7:0.
`include "hsv_to_rgb_percent_unit_assert.svh"

module hsv_to_rgb_percent_unit
  import hsvrgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hsvrgb_in_if.sink     in_hsv,
  hsvrgb_out_if.source  out_rgb
);

  // Valid bit of the output register.
  logic out_v_r;

  // Every stage moves forward whenever the output register is free or being
  // drained this cycle.
  logic adv;
  assign adv          = !out_v_r || out_rgb.ready;
  assign in_hsv.ready = adv;

  // -------------------------------------------------------------------------
  // Stage 1: wrap the hue, clamp the percentages, split hue into sector and
  // remainder with a bank of parallel compares.
  // -------------------------------------------------------------------------
  logic [HueW-1:0] hue_w;
  logic [2:0]      sec_num;
  sector_t         sec_nxt;
  logic [HueW-1:0] sec_base;
  logic [RemW-1:0] rem_nxt;
  logic [PctW-1:0] sat_nxt;
  logic [PctW-1:0] val_nxt;

  always_comb begin
    hue_w   = (in_hsv.hue >= HueWrap) ? in_hsv.hue - HueWrap : in_hsv.hue;
    sec_num = 3'(hue_w >= SectorSpan) + 3'(hue_w >= 9'(2 * SectorSpan))
            + 3'(hue_w >= 9'(3 * SectorSpan)) + 3'(hue_w >= 9'(4 * SectorSpan))
            + 3'(hue_w >= 9'(5 * SectorSpan));
    sec_nxt = sector_t'(sec_num);
    case (sec_nxt)
      SecRedYellow:   sec_base = '0;
      SecYellowGreen: sec_base = SectorSpan;
      SecGreenCyan:   sec_base = 9'(2 * SectorSpan);
      SecCyanBlue:    sec_base = 9'(3 * SectorSpan);
      SecBlueMagenta: sec_base = 9'(4 * SectorSpan);
      default:        sec_base = 9'(5 * SectorSpan);
    endcase
    rem_nxt = RemW'(hue_w - sec_base);
    sat_nxt = (in_hsv.saturation > PctMax) ? PctMax : in_hsv.saturation;
    val_nxt = (in_hsv.brightness > PctMax) ? PctMax : in_hsv.brightness;
  end

  logic            s1_v_r;
  sector_t         s1_sec_r;
  logic [RemW-1:0] s1_rem_r;
  logic [PctW-1:0] s1_sat_r;
  logic [PctW-1:0] s1_val_r;

  // -------------------------------------------------------------------------
  // Stage 2: maximum level and percentage products. S*V gives the slope, (100-S)*V the floor.
  // -------------------------------------------------------------------------
  logic             s2_v_r;
  sector_t          s2_sec_r;
  logic [RemW-1:0]  s2_rem_r;
  level_t           s2_lmax_r;
  logic [ProdW-1:0] s2_dv_r;
  logic [ProdW-1:0] s2_sv_r;

  // -------------------------------------------------------------------------
  // Stage 3: minimum level and the span that the remainder adds or removes.
  // The span never exceeds lmax - lmin because the remainder stays below 60.
  // -------------------------------------------------------------------------
  logic    s3_v_r;
  sector_t s3_sec_r;
  level_t  s3_lmax_r;
  level_t  s3_lmin_r;
  level_t  s3_span_r;

  // -------------------------------------------------------------------------
  // Stage 4: rising and falling edges and the six-sector channel table.
  // -------------------------------------------------------------------------
  level_t lrise;
  level_t lfall;
  level_t red_lvl;
  level_t green_lvl;
  level_t blue_lvl;

  always_comb begin
    lrise = s3_lmin_r + s3_span_r;
    lfall = s3_lmax_r - s3_span_r;
    case (s3_sec_r)
      SecRedYellow: begin
        red_lvl = s3_lmax_r; green_lvl = lrise;     blue_lvl = s3_lmin_r;
      end
      SecYellowGreen: begin
        red_lvl = lfall;     green_lvl = s3_lmax_r; blue_lvl = s3_lmin_r;
      end
      SecGreenCyan: begin
        red_lvl = s3_lmin_r; green_lvl = s3_lmax_r; blue_lvl = lrise;
      end
      SecCyanBlue: begin
        red_lvl = s3_lmin_r; green_lvl = lfall;     blue_lvl = s3_lmax_r;
      end
      SecBlueMagenta: begin
        red_lvl = lrise;     green_lvl = s3_lmin_r; blue_lvl = s3_lmax_r;
      end
      default: begin
        red_lvl = s3_lmax_r; green_lvl = s3_lmin_r; blue_lvl = lfall;
      end
    endcase
  end

  logic   s4_v_r;
  level_t s4_red_r;
  level_t s4_green_r;
  level_t s4_blue_r;

  // -------------------------------------------------------------------------
  // Stage 5 (output register): scale each level to a byte by a reciprocal
  // multiply, then saturate the single out-of-range value 256 to 255.
  // -------------------------------------------------------------------------
  function automatic chan_t to_byte(input level_t lvl);
    logic [LevelW+RecipW-1:0] prod;
    logic [QuotW-1:0]         quot;
    prod = (LevelW+RecipW)'(lvl) * (LevelW+RecipW)'(ByteRecip);
    quot = prod[QuotLo +: QuotW];
    return quot[QuotW-1] ? ChanMax : quot[ChanW-1:0];
  endfunction

  chan_t red_r;
  chan_t green_r;
  chan_t blue_r;

  // Valid bits: cleared by reset, shifted with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_hsv.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sec_r   <= sec_nxt;
      s1_rem_r   <= rem_nxt;
      s1_sat_r   <= sat_nxt;
      s1_val_r   <= val_nxt;

      s2_sec_r   <= s1_sec_r;
      s2_rem_r   <= s1_rem_r;
      s2_lmax_r  <= LevelW'(s1_val_r) * LevelScale;
      s2_dv_r    <= ProdW'(PctMax - s1_sat_r) * ProdW'(s1_val_r);
      s2_sv_r    <= ProdW'(s1_sat_r) * ProdW'(s1_val_r);

      s3_sec_r   <= s2_sec_r;
      s3_lmax_r  <= s2_lmax_r;
      s3_lmin_r  <= LevelW'(s2_dv_r) * MinScale;
      s3_span_r  <= LevelW'(s2_sv_r) * LevelW'(s2_rem_r);

      s4_red_r   <= red_lvl;
      s4_green_r <= green_lvl;
      s4_blue_r  <= blue_lvl;

      red_r      <= to_byte(s4_red_r);
      green_r    <= to_byte(s4_green_r);
      blue_r     <= to_byte(s4_blue_r);
    end
  end

  assign out_rgb.valid        = out_v_r;
  assign out_rgb.red          = red_r;
  assign out_rgb.green        = green_r;
  assign out_rgb.blue         = blue_r;
  assign out_rgb.packed_color = {blue_r, green_r, red_r};

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  // The rising edge never overshoots the maximum level.
  `HSVRGB_CHECK_IMPL(a_span_bound, clk, rst_n, s3_v_r,
                     (21'(s3_lmin_r) + 21'(s3_span_r)) <= 21'(s3_lmax_r))
  // Every selected level stays within full scale.
  `HSVRGB_CHECK_IMPL(a_level_bound, clk, rst_n, s4_v_r,
                     s4_red_r <= 20'(PctMax) * LevelScale
                     && s4_green_r <= 20'(PctMax) * LevelScale
                     && s4_blue_r <= 20'(PctMax) * LevelScale)
  // A stalled pipeline keeps the word waiting ahead of the output register.
  `HSVRGB_CHECK_NEXT(a_stall_hold, clk, rst_n, s4_v_r && !adv,
                     s4_v_r && $stable(s4_red_r) && $stable(s4_green_r)
                     && $stable(s4_blue_r))
  // A word in the last stage moves to the output when the pipeline advances.
  `HSVRGB_CHECK_NEXT(a_no_drop, clk, rst_n, s4_v_r && adv, out_v_r)

endmodule
